[rtl/core/tip_pkg.sv]
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types and constants for the telnet IAC negotiation parser.
// ----------------------------------------------------------------------------
package tip_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_IS   = 8'h00;
  localparam logic [7:0] B_SEND = 8'h01;

  // Option codes
  localparam logic [7:0] OPT_TTYPE = 8'h18;
  localparam logic [7:0] OPT_ECHO  = 8'h01;

  // Terminal name storage
  localparam int unsigned NameBytes = 8;
  localparam logic [3:0]  NAME_MAX  = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_TERM_NAME     = 2'd0;
  localparam logic [1:0] REG_TERM_NAME_LEN = 2'd1;

  // Result channels
  localparam logic [1:0] CH_DATA  = 2'd0;
  localparam logic [1:0] CH_REPLY = 2'd1;
  localparam logic [1:0] CH_ECHO  = 2'd2;

  // Negotiation command codes
  localparam logic [1:0] CMD_WILL = 2'd0;
  localparam logic [1:0] CMD_WONT = 2'd1;
  localparam logic [1:0] CMD_DO   = 2'd2;
  localparam logic [1:0] CMD_DONT = 2'd3;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_NEG    = 3'd2,
    PH_SBOPT  = 3'd3,
    PH_SBDATA = 3'd4,
    PH_SBIAC  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_DATA  = 2'd1,
    JOB_NEG   = 2'd2,
    JOB_TTYPE = 2'd3
  } job_kind_t;

  // Work handed from the parser to the emitter for one input byte
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;    // data byte or option
    logic [7:0] verb;     // reply verb for negotiation
    logic       echo;     // negotiation emits an echo change first
    logic       echo_off; // echo change direction
  } job_t;

endpackage

[rtl/core/telnet_iac_negotiation_parser.sv]
// ----------------------------------------------------------------------------
// telnet_iac_negotiation_parser
// Telnet receive-side IAC parser with option negotiation replies.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction. Plain bytes and IAC IAC pass the
// job register and then the output register to channel 0; a plain data stream
// runs at one byte per cycle while out_stall is low. A negotiation answer (3
// reply bytes, 4 with an echo change) or a terminal type reply (6 bytes plus
// the name length) is sent one item per cycle from the result sequencer while
// out_stall is low; in_stall stays high until that job's last item moves into
// the output register. A byte that produces nothing (IAC commands,
// subnegotiation payload) loads no job. The output register lets the next
// byte enter while the previous result waits on out_stall. Write term_name and
// term_name_len only while the block is idle; cfg_ready is always high.
module telnet_iac_negotiation_parser
  import tip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             channel,
  output logic [7:0]             out_byte,
  output logic                   echo_off,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [8*NameBytes-1:0] cfg_data
);

  logic [8*NameBytes-1:0] term_name;
  logic [3:0]             term_name_len;
  logic                   accept;
  logic                   busy;
  job_t                   job;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      term_name     <= '0;
      term_name_len <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TERM_NAME:     term_name     <= cfg_data;
        REG_TERM_NAME_LEN: term_name_len <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tip_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .job     (job)
  );

  tip_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && job.kind != JOB_NONE),
    .job_in    (job),
    .name_len  (term_name_len),
    .term_name (term_name),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .out_byte  (out_byte),
    .echo_off  (echo_off),
    .last      (last)
  );

endmodule

[rtl/core/tip_parser.sv]
// ----------------------------------------------------------------------------
// tip_parser
// Telnet receive state machine: tracks IAC, negotiation and subnegotiation
// phases and turns each accepted byte into a job for the emitter.
// ----------------------------------------------------------------------------
module tip_parser
  import tip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output job_t       job
);

  phase_t     parse_phase, parse_phase_next;
  logic [1:0] neg_command, neg_command_next;
  logic [7:0] sub_option, sub_option_next;
  logic [1:0] sub_count, sub_count_next;
  logic [7:0] sub_first, sub_first_next;

  logic [1:0] count_one;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_DATA;
      neg_command <= CMD_WILL;
      sub_option  <= 8'd0;
      sub_count   <= 2'd0;
      sub_first   <= 8'd0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      neg_command <= neg_command_next;
      sub_option  <= sub_option_next;
      sub_count   <= sub_count_next;
      sub_first   <= sub_first_next;
    end
  end

  // Payload count after one more byte, saturating at two
  assign count_one = (sub_count == 2'd2) ? 2'd2 : sub_count + 2'd1;

  // Decode the byte against the current phase
  always_comb begin
    parse_phase_next = PH_DATA;
    neg_command_next = neg_command;
    sub_option_next  = sub_option;
    sub_count_next   = sub_count;
    sub_first_next   = sub_first;
    job              = '{kind: JOB_NONE, value: rx_byte, verb: B_WONT,
                         echo: 1'b0, echo_off: 1'b0};
    unique case (parse_phase)
      PH_IAC: begin
        priority if (rx_byte == B_IAC) begin
          job.kind = JOB_DATA;
          parse_phase_next = PH_DATA;
        end else if (rx_byte >= B_WILL && rx_byte <= B_DONT) begin
          neg_command_next = 2'(rx_byte - B_WILL);
          parse_phase_next = PH_NEG;
        end else if (rx_byte == B_SB) begin
          parse_phase_next = PH_SBOPT;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
      PH_NEG: begin
        job.kind = JOB_NEG;
        if (neg_command == CMD_WILL || neg_command == CMD_WONT) begin
          job.echo     = (rx_byte == OPT_ECHO);
          job.echo_off = (neg_command == CMD_WONT);
          job.verb     = (neg_command == CMD_WONT) ? B_DONT : B_DO;
        end else begin
          job.verb = (neg_command == CMD_DO && rx_byte == OPT_TTYPE) ? B_WILL : B_WONT;
        end
        parse_phase_next = PH_DATA;
      end
      PH_SBOPT: begin
        sub_option_next  = rx_byte;
        sub_count_next   = 2'd0;
        sub_first_next   = 8'd0;
        parse_phase_next = PH_SBDATA;
      end
      PH_SBDATA: begin
        if (rx_byte == B_IAC) begin
          parse_phase_next = PH_SBIAC;
        end else begin
          if (sub_count == 2'd0) begin
            sub_first_next = rx_byte;
          end
          sub_count_next   = count_one;
          parse_phase_next = PH_SBDATA;
        end
      end
      PH_SBIAC: begin
        if (rx_byte == B_SE) begin
          if (sub_option == OPT_TTYPE && sub_count == 2'd1 && sub_first == B_SEND) begin
            job.kind = JOB_TTYPE;
          end
          parse_phase_next = PH_DATA;
        end else begin
          // Escaped IAC adds one payload byte; a stray IAC adds two
          if (sub_count == 2'd0) begin
            sub_first_next = B_IAC;
          end
          sub_count_next   = (rx_byte == B_IAC) ? count_one : 2'd2;
          parse_phase_next = PH_SBDATA;
        end
      end
      default: begin
        if (rx_byte == B_IAC) begin
          parse_phase_next = PH_IAC;
        end else begin
          job.kind = JOB_DATA;
          parse_phase_next = PH_DATA;
        end
      end
    endcase
  end

endmodule

[rtl/core/tip_emitter.sv]
// ----------------------------------------------------------------------------
// tip_emitter
// Holds one job and steps through its result items into the output register,
// one per cycle while the output register is not stalled.
// ----------------------------------------------------------------------------
module tip_emitter
  import tip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  job_t                   job_in,
  input  logic [3:0]             name_len,
  input  logic [8*NameBytes-1:0] term_name,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             channel,
  output logic [7:0]             out_byte,
  output logic                   echo_off,
  output logic                   last
);

  logic       job_valid;
  job_t       job;
  logic [3:0] idx;
  logic [3:0] n_len;

  logic       out_load;
  logic       emit;
  logic [3:0] last_idx;
  logic       job_last;
  logic [1:0] item_channel;
  logic [7:0] item_byte;
  logic       item_echo_off;
  logic [2:0] name_sel;

  assign out_load = !out_valid || !out_stall;
  assign emit     = job_valid && out_load;
  assign job_last = (idx == last_idx);
  assign busy     = job_valid && !(emit && job_last);
  assign name_sel = 3'(n_len + 4'd3 - idx);

  // Job register and item counter
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
    end else if (emit && job_last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job   <= job_in;
      n_len <= (name_len > NAME_MAX) ? NAME_MAX : name_len;
      idx   <= (job_in.kind == JOB_NEG && !job_in.echo) ? 4'd1 : 4'd0;
    end else if (emit) begin
      idx <= idx + 4'd1;
    end
  end

  // Select the current item
  always_comb begin
    item_channel  = CH_REPLY;
    item_byte     = 8'd0;
    item_echo_off = 1'b0;
    last_idx      = 4'd0;
    unique case (job.kind)
      JOB_DATA: begin
        item_channel = CH_DATA;
        item_byte    = job.value;
      end
      JOB_NEG: begin
        last_idx = 4'd3;
        unique case (idx)
          4'd0: begin
            item_channel  = CH_ECHO;
            item_echo_off = job.echo_off;
          end
          4'd1:    item_byte = B_IAC;
          4'd2:    item_byte = job.verb;
          default: item_byte = job.value;
        endcase
      end
      JOB_TTYPE: begin
        last_idx = n_len + 4'd5;
        priority if (idx == 4'd0) begin
          item_byte = B_IAC;
        end else if (idx == 4'd1) begin
          item_byte = B_SB;
        end else if (idx == 4'd2) begin
          item_byte = OPT_TTYPE;
        end else if (idx == 4'd3) begin
          item_byte = B_IS;
        end else if (idx == last_idx) begin
          item_byte = B_SE;
        end else if (idx == last_idx - 4'd1) begin
          item_byte = B_IAC;
        end else begin
          item_byte = term_name[8*name_sel +: 8];
        end
      end
      default: begin
        item_channel = CH_DATA;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel  <= item_channel;
      out_byte <= item_byte;
      echo_off <= item_echo_off;
      last     <= job_last;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx <= last_idx)
    else $error("item counter ran past the last item of the job");

  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !emit) |=> (job_valid && $stable(idx)))
    else $error("job changed while the output register was stalled");

  a_job_continues: assert property (@(posedge clk) disable iff (rst)
    (emit && !job_last) |=> job_valid)
    else $error("job dropped before its last item");

  a_echo_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && channel == CH_ECHO) |-> !last)
    else $error("echo change marked as last item");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !load)
    else $error("new job loaded while the current one is in flight");
`endif

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telnet IAC negotiation parser.
// ----------------------------------------------------------------------------
// A scoreboard class tracks the parser state and the terminal name registers.
// It predicts every data byte, negotiation answer, echo change and terminal
// type reply for each received byte that the block accepts, and compares
// every output transaction field by field, in order.
//
// The run is split into phases. Each phase after the first writes a new name
// setting while the block is idle; each phase then sends a byte stream. The
// first phase is a short directed stream. The later phases start with a
// terminal type request and are filled with random, mostly well-formed telnet
// sequences plus noise; input gaps and output stalls are random. In one phase
// the output holds off a long stretch, so the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb
  import tip_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int          NUM_PHASES       = 6;
  localparam int          RANDOM_PER_PHASE = 64;
  localparam int          DRAIN_CYCLES     = 20;
  localparam int          LONG_HOLD        = 300;
  localparam int          MAX_REPORTS      = 10;
  localparam int          PRESSURE_PHASE   = 2;
  localparam logic [1:0]  REG_UNUSED       = 2'd3;

  typedef struct packed {
    logic [1:0] chan;
    logic [7:0] value;
    logic       echo;
    logic       tail;
  } parser_out_t;

  // Parser state and name registers, plus the queue of outputs still owed
  class telnet_reply_scoreboard;
    parser_out_t parser_out_q[$];
    phase_t      phase     = PH_DATA;
    logic [1:0]  neg_cmd   = CMD_WILL;
    logic [7:0]  sub_opt   = 8'h00;
    logic [1:0]  sub_cnt   = 2'd0;
    logic [7:0]  sub_first = 8'h00;
    logic [63:0] name      = 64'h0;
    logic [3:0]  name_len  = 4'd0;
    int          mismatches = 0;

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      if (idx == REG_TERM_NAME) begin
        name = data;
      end else if (idx == REG_TERM_NAME_LEN) begin
        name_len = data[3:0];
      end
    endfunction

    function void owe(logic [1:0] chan, logic [7:0] value, logic echo, logic tail);
      parser_out_t item;
      item.chan  = chan;
      item.value = value;
      item.echo  = echo;
      item.tail  = tail;
      parser_out_q.push_back(item);
    endfunction

    // Count one subnegotiation payload byte, remembering the first
    function void add_payload(logic [7:0] b);
      if (sub_cnt == 2'd0) begin
        sub_first = b;
      end
      if (sub_cnt < 2'd2) begin
        sub_cnt = sub_cnt + 2'd1;
      end
    endfunction

    // Advance the parser by one accepted byte and queue what it causes
    function void note_rx_byte(logic [7:0] b);
      logic [7:0] verb;
      int         n;
      int         i;
      case (phase)
        PH_IAC: begin
          if (b == B_IAC) begin
            owe(CH_DATA, B_IAC, 1'b0, 1'b1);
            phase = PH_DATA;
          end else if (b >= B_WILL && b <= B_DONT) begin
            neg_cmd = 2'(b - B_WILL);
            phase = PH_NEG;
          end else if (b == B_SB) begin
            phase = PH_SBOPT;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_NEG: begin
          // answer WILL/WONT with DO/DONT, echo change first for the echo option
          if (neg_cmd == CMD_WILL || neg_cmd == CMD_WONT) begin
            if (b == OPT_ECHO) begin
              owe(CH_ECHO, 8'h00, neg_cmd == CMD_WONT, 1'b0);
            end
            verb = (neg_cmd == CMD_WONT) ? B_DONT : B_DO;
          end else begin
            verb = (neg_cmd == CMD_DO && b == OPT_TTYPE) ? B_WILL : B_WONT;
          end
          owe(CH_REPLY, B_IAC, 1'b0, 1'b0);
          owe(CH_REPLY, verb, 1'b0, 1'b0);
          owe(CH_REPLY, b, 1'b0, 1'b1);
          phase = PH_DATA;
        end
        PH_SBOPT: begin
          sub_opt   = b;
          sub_cnt   = 2'd0;
          sub_first = 8'h00;
          phase     = PH_SBDATA;
        end
        PH_SBDATA: begin
          if (b == B_IAC) begin
            phase = PH_SBIAC;
          end else begin
            add_payload(b);
          end
        end
        PH_SBIAC: begin
          if (b == B_SE) begin
            // terminal type SEND gets IAC SB 24 IS <name> IAC SE
            if (sub_opt == OPT_TTYPE && sub_cnt == 2'd1 && sub_first == B_SEND) begin
              n = (name_len > NAME_MAX) ? NAME_MAX : name_len;
              owe(CH_REPLY, B_IAC, 1'b0, 1'b0);
              owe(CH_REPLY, B_SB, 1'b0, 1'b0);
              owe(CH_REPLY, OPT_TTYPE, 1'b0, 1'b0);
              owe(CH_REPLY, B_IS, 1'b0, 1'b0);
              for (i = 0; i < n; i++) begin
                owe(CH_REPLY, name[8*(n-1-i) +: 8], 1'b0, 1'b0);
              end
              owe(CH_REPLY, B_IAC, 1'b0, 1'b0);
              owe(CH_REPLY, B_SE, 1'b0, 1'b1);
            end
            phase = PH_DATA;
          end else begin
            add_payload(B_IAC);
            if (b != B_IAC) begin
              add_payload(b);
            end
            phase = PH_SBDATA;
          end
        end
        default: begin
          if (b == B_IAC) begin
            phase = PH_IAC;
          end else begin
            owe(CH_DATA, b, 1'b0, 1'b1);
            phase = PH_DATA;
          end
        end
      endcase
    endfunction

    // Compare one output transaction with the oldest owed item
    function void check_output(logic [1:0] chan, logic [7:0] value, logic echo,
                               logic tail);
      parser_out_t want;
      if (parser_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: unexpected output ch=%0d byte=%02h echo_off=%0b last=%0b",
                   chan, value, echo, tail);
        end
        return;
      end
      want = parser_out_q.pop_front();
      if (want.chan !== chan || want.value !== value || want.echo !== echo ||
          want.tail !== tail) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: mismatch exp ch=%0d byte=%02h echo_off=%0b last=%0b",
                   want.chan, want.value, want.echo, want.tail,
                   ", got ch=%0d byte=%02h echo_off=%0b last=%0b",
                   chan, value, echo, tail);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  channel;
  logic [7:0]  out_byte;
  logic        echo_off;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_TERM_NAME;
  logic [63:0] cfg_data  = 64'h0;

  telnet_reply_scoreboard sb;
  logic [7:0]  stream_q[$];
  int          in_gap_max    = 0;
  int          out_stall_max = 0;
  bit          hold_output   = 1'b0;
  int unsigned cycle_count   = 0;

  telnet_iac_negotiation_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .out_byte  (out_byte),
    .echo_off  (echo_off),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Append IAC SB opt <payload> IAC SE; a request is a plain terminal type SEND
  function automatic void add_subnegotiation(bit request);
    int         n;
    logic [7:0] x;
    stream_q.push_back(B_IAC);
    stream_q.push_back(B_SB);
    stream_q.push_back((request || $urandom_range(0, 1)) ? OPT_TTYPE :
                       8'($urandom_range(0, 255)));
    if (request || $urandom_range(0, 2) == 0) begin
      stream_q.push_back(B_SEND);
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: stream_q.push_back(B_SEND);
          1: stream_q.push_back(8'($urandom_range(0, 254)));
          2: begin
            // escaped IAC
            stream_q.push_back(B_IAC);
            stream_q.push_back(B_IAC);
          end
          default: begin
            // stray IAC followed by neither SE nor IAC
            x = 8'($urandom_range(0, 254));
            if (x == B_SE) x = B_SEND;
            stream_q.push_back(B_IAC);
            stream_q.push_back(x);
          end
        endcase
      end
    end
    stream_q.push_back(B_IAC);
    stream_q.push_back(B_SE);
  endfunction

  // Append one random sequence, mostly well formed, sometimes raw noise
  function automatic void add_random_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      stream_q.push_back(8'($urandom_range(0, 254)));
    end else if (kind < 38) begin
      stream_q.push_back(B_IAC);
      stream_q.push_back(B_IAC);
    end else if (kind < 44) begin
      stream_q.push_back(B_IAC);
      stream_q.push_back(8'($urandom_range(0, 8'hF9)));
    end else if (kind < 70) begin
      stream_q.push_back(B_IAC);
      stream_q.push_back(8'($urandom_range(B_WILL, B_DONT)));
      case ($urandom_range(0, 3))
        0: stream_q.push_back(OPT_ECHO);
        1: stream_q.push_back(OPT_TTYPE);
        default: stream_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (kind < 90) begin
      add_subnegotiation(1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_rx_byte(b);
  endtask

  // Write one register; the caller drops cfg_valid after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, data);
  endtask

  // Wait for every owed output, then let the block settle
  task automatic wait_idle();
    while (sb.parser_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: random stall before each transaction, one long hold on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        stall = LONG_HOLD;
        hold_output = 1'b0;
      end else begin
        stall = $urandom_range(0, out_stall_max);
      end
      repeat (stall) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      sb.check_output(channel, out_byte, echo_off, last);
    end
  end

  initial begin
    int          p;
    logic [63:0] name_val;
    logic [63:0] junk;
    logic [3:0]  len_val;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      stream_q.delete();
      name_val = {$urandom, $urandom};
      case (p)
        0: begin in_gap_max = 0;  out_stall_max = 0;  len_val = 4'd0; end
        1: begin
          in_gap_max = 10; out_stall_max = 10;
          name_val = 64'h0000_0078_7465_726D;
          len_val = 4'd5;
        end
        2: begin
          in_gap_max = 0; out_stall_max = 10;
          name_val = '1;
          len_val = NAME_MAX;
        end
        3: begin in_gap_max = 3;  out_stall_max = 0;  len_val = 4'd15; end
        4: begin in_gap_max = 10; out_stall_max = 0;  len_val = 4'd1;  end
        default: begin in_gap_max = 0; out_stall_max = 3; len_val = 4'd0; end
      endcase

      // update the name registers while the block is idle
      if (p != 0) begin
        write_reg(REG_TERM_NAME, name_val);
        junk = {$urandom, $urandom};
        write_reg(REG_TERM_NAME_LEN, {junk[63:4], len_val});
        if (p == 3) begin
          write_reg(REG_UNUSED, junk);
        end
        cfg_valid <= 1'b0;
      end

      if (p == 0) begin
        // extremes, IAC escape, dropped command, each verb, echo, a name request
        stream_q = '{8'h00, 8'hFE, B_IAC, B_IAC, B_IAC, 8'hF1,
                     B_IAC, B_WILL, OPT_ECHO, B_IAC, B_WONT, OPT_ECHO,
                     B_IAC, B_DO, OPT_TTYPE, B_IAC, B_DONT, B_IAC,
                     B_IAC, B_SB, OPT_TTYPE, B_SEND, B_IAC, B_SE};
      end else begin
        add_subnegotiation(1'b1);
        while (stream_q.size() < RANDOM_PER_PHASE) add_random_sequence();
      end

      if (p == PRESSURE_PHASE) begin
        hold_output = 1'b1;
      end
      foreach (stream_q[i]) send_rx_byte(stream_q[i]);
      in_valid <= 1'b0;
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
